### rtl/core/cic_pkg.sv
package cic_pkg;

	// packed so that the first circle's x position sits in the lowest bits
	typedef struct packed {
		logic signed [31:0] v2y;
		logic signed [31:0] v2x;
		logic signed [31:0] p2y;
		logic signed [31:0] p2x;
		logic signed [31:0] v1y;
		logic signed [31:0] v1x;
		logic signed [31:0] p1y;
		logic signed [31:0] p1x;
	} coords_t;

	typedef struct packed {
		coords_t            crd;
		logic signed [32:0] dvx;
		logic signed [32:0] dvy;
		logic [31:0]        min_dist;
		logic [30:0]        m1;
		logic [30:0]        m2;
		logic [31:0]        tot;
		logic [31:0]        ax;
		logic [31:0]        ay;
		logic               sgnx;
		logic               sgny;
		logic               far;
	} ctx_t;

	localparam logic [16:0] RESTIT_RESET = 17'd36045;
	localparam logic [17:0] RESTIT_ONE   = 18'd65536;
	localparam int unsigned RESTIT_FRAC  = 16;
	localparam int unsigned SQRT_STEPS   = 32;

	function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
		logic signed [31:0] r;
		if (v > 42'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -42'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

### rtl/core/circle_impulse_collision.sv
// Two-circle contact resolver, one circle pair per transaction.
// s_axis: a pair of circles (position and velocity signed, mass and radius
// unsigned, fixed point with FRAC_BITS fraction bits); a transaction is taken when
// tvalid and tready are both high. m_axis: both circles after contact,
// with tuser flags for overlap and applied impulse.
// cfg: writes the restitution register (unsigned Q1.16) on cfg_valid,
// cfg_ready is always high; write only while the pipeline is empty.
// Pipeline: 44 + FRAC_BITS register stages, among them the 32 one-bit
// square root stages and the FRAC_BITS+1 one-bit divider stages.
// Throughput: one pair per cycle while m_axis_tready is high.
// Every stage holds a valid bit; a stage moves when it is empty or when the
// stage after it moves, so a stall on m_axis_tready fills the empty stages
// first and only then drops s_axis_tready. Nothing is dropped or repeated.
// Reset clears all valid bits and loads restitution with 36045 (0.55).
module circle_impulse_collision #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	// pos1_x, pos1_y, vel1_x, vel1_y, mass1, radius1,
	// pos2_x, pos2_y, vel2_x, vel2_y, mass2, radius2
	input  logic [383:0] s_axis_tdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// new_pos1_x, new_pos1_y, new_vel1_x, new_vel1_y,
	// new_pos2_x, new_pos2_y, new_vel2_x, new_vel2_y
	output logic [255:0] m_axis_tdata,
	// overlapping, impulse_applied
	output logic [1:0]   m_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [16:0]  cfg_data,
	input  logic         cfg_valid,
	output logic         cfg_ready
);

	localparam int F    = FRAC_BITS;
	localparam int NW   = F + 1;
	localparam int NSQ  = cic_pkg::SQRT_STEPS;
	localparam int NDV  = NW;
	localparam int P_SQ = 3;
	localparam int P_CK = P_SQ + NSQ;
	localparam int P_DV = P_CK + 1;
	localparam int P_E1 = P_DV + NDV;
	localparam int P_E2 = P_E1 + 1;
	localparam int P_E3 = P_E2 + 1;
	localparam int P_E4 = P_E3 + 1;
	localparam int P_E5 = P_E4 + 1;
	localparam int P_E6 = P_E5 + 1;
	localparam int P_OUT = P_E6 + 1;
	localparam int NST  = P_OUT + 1;
	localparam logic [31:0] EPS = 32'((64'd1 << F) / 10000);

	typedef struct packed {
		logic [31:0]   rem;
		logic [31:0]   dvs;
		logic [NW-1:0] q;
		logic          low;
	} div_t;

	logic [16:0]    restit_q;
	logic [NST-1:0] stage_vld_q;
	logic [NST:0]   stage_en;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restit_q <= cic_pkg::RESTIT_RESET;
		end else if (cfg_valid) begin
			restit_q <= cfg_data;
		end
	end

	// flow control
	always_comb begin
		stage_en[NST] = m_axis_tready;
		for (int i = NST - 1; i >= 0; i--) begin
			stage_en[i] = !stage_vld_q[i] || stage_en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				stage_vld_q[0] <= s_axis_tvalid;
			end
			for (int i = 1; i < NST; i++) begin
				if (stage_en[i]) begin
					stage_vld_q[i] <= stage_vld_q[i-1];
				end
			end
		end
	end

	assign s_axis_tready = stage_en[0];

	// stage 1: differences, sums, mass fix
	cic_pkg::ctx_t      in_ctx;
	logic signed [31:0] in_p1x, in_p1y, in_p2x, in_p2y;
	logic signed [31:0] in_v1x, in_v1y, in_v2x, in_v2y;
	logic [30:0]        in_m1, in_m2, in_r1, in_r2, m1_fix, m2_fix;
	logic signed [32:0] dx_c, dy_c;
	logic [32:0]        adx_c, ady_c;

	always_comb begin
		in_p1x = s_axis_tdata[31:0];
		in_p1y = s_axis_tdata[63:32];
		in_v1x = s_axis_tdata[95:64];
		in_v1y = s_axis_tdata[127:96];
		in_m1  = s_axis_tdata[158:128];
		in_r1  = s_axis_tdata[189:159];
		in_p2x = s_axis_tdata[221:190];
		in_p2y = s_axis_tdata[253:222];
		in_v2x = s_axis_tdata[285:254];
		in_v2y = s_axis_tdata[317:286];
		in_m2  = s_axis_tdata[348:318];
		in_r2  = s_axis_tdata[379:349];
		m1_fix = (in_m1 == '0) ? 31'd1 : in_m1;
		m2_fix = (in_m2 == '0) ? 31'd1 : in_m2;
		dx_c   = $signed({in_p2x[31], in_p2x}) - $signed({in_p1x[31], in_p1x});
		dy_c   = $signed({in_p2y[31], in_p2y}) - $signed({in_p1y[31], in_p1y});
		adx_c  = dx_c[32] ? 33'(-dx_c) : dx_c;
		ady_c  = dy_c[32] ? 33'(-dy_c) : dy_c;
		in_ctx.crd.p1x = in_p1x;
		in_ctx.crd.p1y = in_p1y;
		in_ctx.crd.v1x = in_v1x;
		in_ctx.crd.v1y = in_v1y;
		in_ctx.crd.p2x = in_p2x;
		in_ctx.crd.p2y = in_p2y;
		in_ctx.crd.v2x = in_v2x;
		in_ctx.crd.v2y = in_v2y;
		in_ctx.dvx      = $signed({in_v2x[31], in_v2x}) - $signed({in_v1x[31], in_v1x});
		in_ctx.dvy      = $signed({in_v2y[31], in_v2y}) - $signed({in_v1y[31], in_v1y});
		in_ctx.min_dist = {1'b0, in_r1} + {1'b0, in_r2};
		in_ctx.m1       = m1_fix;
		in_ctx.m2       = m2_fix;
		in_ctx.tot      = {1'b0, m1_fix} + {1'b0, m2_fix};
		in_ctx.ax       = adx_c[31:0];
		in_ctx.ay       = ady_c[31:0];
		in_ctx.sgnx     = dx_c[32];
		in_ctx.sgny     = dy_c[32];
		in_ctx.far      = 1'b0;
	end

	cic_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3;
	logic [63:0]   a2_s2, b2_s2, x_s3;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			ctx_s1 <= in_ctx;
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			ctx_s2 <= ctx_s1;
			a2_s2  <= ctx_s1.ax * ctx_s1.ax;
			b2_s2  <= ctx_s1.ay * ctx_s1.ay;
		end
	end

	// stage 3: squared distance, overflow marks no contact
	logic [64:0]   sum_c;
	cic_pkg::ctx_t ctx3_c;

	always_comb begin
		sum_c      = {1'b0, a2_s2} + {1'b0, b2_s2};
		ctx3_c     = ctx_s2;
		ctx3_c.far = sum_c[64];
	end

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			ctx_s3 <= ctx3_c;
			x_s3   <= sum_c[63:0];
		end
	end

	// square root, one result bit per stage
	cic_pkg::ctx_t sq_ctx_s4  [NSQ];
	logic [33:0]   sq_rem_s4  [NSQ];
	logic [31:0]   sq_root_s4 [NSQ];
	logic [63:0]   sq_x_s4    [NSQ];

	for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
		cic_pkg::ctx_t ctx_in;
		logic [33:0]   rem_in;
		logic [31:0]   root_in;
		logic [63:0]   x_in;
		logic [35:0]   remw, trial, diff;
		logic          ge;

		if (i == 0) begin : g_first
			assign ctx_in  = ctx_s3;
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = x_s3;
		end else begin : g_next
			assign ctx_in  = sq_ctx_s4[i-1];
			assign rem_in  = sq_rem_s4[i-1];
			assign root_in = sq_root_s4[i-1];
			assign x_in    = sq_x_s4[i-1];
		end

		always_comb begin
			remw  = {rem_in, x_in[63:62]};
			trial = {2'b00, root_in, 2'b01};
			ge    = remw >= trial;
			diff  = remw - trial;
		end

		always_ff @(posedge clk) begin
			if (stage_en[P_SQ+i]) begin
				sq_ctx_s4[i]  <= ctx_in;
				sq_rem_s4[i]  <= ge ? diff[33:0] : remw[33:0];
				sq_root_s4[i] <= {root_in[30:0], ge};
				sq_x_s4[i]    <= {x_in[61:0], 2'b00};
			end
		end
	end

	// contact test, divider setup
	cic_pkg::ctx_t ck_ctx;
	logic [31:0]   dist_c;
	logic          hit_c;
	div_t          ck_div [4];
	logic [31:0]   ck_num [4];

	always_comb begin
		ck_ctx    = sq_ctx_s4[NSQ-1];
		dist_c    = sq_root_s4[NSQ-1];
		hit_c     = !ck_ctx.far && (dist_c > EPS) && (dist_c < ck_ctx.min_dist);
		ck_num[0] = ck_ctx.ax;
		ck_num[1] = ck_ctx.ay;
		ck_num[2] = {1'b0, ck_ctx.m2};
		ck_num[3] = {1'b0, ck_ctx.m1};
		for (int l = 0; l < 4; l++) begin
			ck_div[l].rem = {1'b0, ck_num[l][31:1]};
			ck_div[l].low = ck_num[l][0];
			ck_div[l].q   = '0;
			ck_div[l].dvs = (l < 2) ? dist_c : ck_ctx.tot;
		end
	end

	cic_pkg::ctx_t ctx_s5;
	logic          hit_s5;
	logic [31:0]   pen_s5;
	div_t          div_s5 [4];

	always_ff @(posedge clk) begin
		if (stage_en[P_CK]) begin
			ctx_s5 <= ck_ctx;
			hit_s5 <= hit_c;
			pen_s5 <= ck_ctx.min_dist - dist_c;
			div_s5 <= ck_div;
		end
	end

	// unit normal and mass shares, one quotient bit per stage
	cic_pkg::ctx_t dv_ctx_s6 [NDV];
	logic          dv_hit_s6 [NDV];
	logic [31:0]   dv_pen_s6 [NDV];
	div_t          dv_s6     [NDV][4];

	for (genvar j = 0; j < NDV; j++) begin : g_div
		cic_pkg::ctx_t ctx_in;
		logic          hit_in;
		logic [31:0]   pen_in;
		div_t          din  [4];
		div_t          dout [4];
		logic [32:0]   r2   [4];
		logic [32:0]   df   [4];
		logic          ge   [4];

		if (j == 0) begin : g_first
			assign ctx_in = ctx_s5;
			assign hit_in = hit_s5;
			assign pen_in = pen_s5;
			assign din    = div_s5;
		end else begin : g_next
			assign ctx_in = dv_ctx_s6[j-1];
			assign hit_in = dv_hit_s6[j-1];
			assign pen_in = dv_pen_s6[j-1];
			assign din    = dv_s6[j-1];
		end

		always_comb begin
			for (int l = 0; l < 4; l++) begin
				r2[l]       = {din[l].rem, din[l].low};
				df[l]       = r2[l] - {1'b0, din[l].dvs};
				ge[l]       = r2[l] >= {1'b0, din[l].dvs};
				dout[l].rem = ge[l] ? df[l][31:0] : r2[l][31:0];
				dout[l].dvs = din[l].dvs;
				dout[l].q   = {din[l].q[NW-2:0], ge[l]};
				dout[l].low = 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			if (stage_en[P_DV+j]) begin
				dv_ctx_s6[j] <= ctx_in;
				dv_hit_s6[j] <= hit_in;
				dv_pen_s6[j] <= pen_in;
				dv_s6[j]     <= dout;
			end
		end
	end

	// stage 7: push shares and relative velocity products
	cic_pkg::ctx_t         ctx_s7;
	logic                  hit_s7;
	logic [NW-1:0]         nxm_s7, nym_s7, sh1_s7, sh2_s7;
	logic [32:0]           push1_s7, push2_s7;
	logic signed [33+NW:0] px_s7, py_s7;
	logic signed [NW:0]    nx_c, ny_c;
	logic [31+NW:0]        pp1_c, pp2_c;
	div_t                  qd [4];

	always_comb begin
		qd    = dv_s6[NDV-1];
		nx_c  = dv_ctx_s6[NDV-1].sgnx ? -$signed({1'b0, qd[0].q}) : $signed({1'b0, qd[0].q});
		ny_c  = dv_ctx_s6[NDV-1].sgny ? -$signed({1'b0, qd[1].q}) : $signed({1'b0, qd[1].q});
		pp1_c = dv_pen_s6[NDV-1] * qd[2].q;
		pp2_c = dv_pen_s6[NDV-1] * qd[3].q;
	end

	always_ff @(posedge clk) begin
		if (stage_en[P_E1]) begin
			ctx_s7   <= dv_ctx_s6[NDV-1];
			hit_s7   <= dv_hit_s6[NDV-1];
			nxm_s7   <= qd[0].q;
			nym_s7   <= qd[1].q;
			sh1_s7   <= qd[2].q;
			sh2_s7   <= qd[3].q;
			push1_s7 <= pp1_c[31+NW:F];
			push2_s7 <= pp2_c[31+NW:F];
			px_s7    <= dv_ctx_s6[NDV-1].dvx * nx_c;
			py_s7    <= dv_ctx_s6[NDV-1].dvy * ny_c;
		end
	end

	// stage 8: closing speed, position corrections
	cic_pkg::ctx_t         ctx_s8;
	logic                  hit_s8;
	logic [NW-1:0]         nxm_s8, nym_s8, sh1_s8, sh2_s8;
	logic signed [34+NW:0] s_s8;
	logic [33:0]           c1x_s8, c1y_s8, c2x_s8, c2y_s8;
	logic [32+NW:0]        q1x_c, q1y_c, q2x_c, q2y_c;

	always_comb begin
		q1x_c = nxm_s7 * push1_s7;
		q1y_c = nym_s7 * push1_s7;
		q2x_c = nxm_s7 * push2_s7;
		q2y_c = nym_s7 * push2_s7;
	end

	always_ff @(posedge clk) begin
		if (stage_en[P_E2]) begin
			ctx_s8 <= ctx_s7;
			hit_s8 <= hit_s7;
			nxm_s8 <= nxm_s7;
			nym_s8 <= nym_s7;
			sh1_s8 <= sh1_s7;
			sh2_s8 <= sh2_s7;
			s_s8   <= px_s7 + py_s7;
			c1x_s8 <= q1x_c[32+NW:F];
			c1y_s8 <= q1y_c[32+NW:F];
			c2x_s8 <= q2x_c[32+NW:F];
			c2y_s8 <= q2y_c[32+NW:F];
		end
	end

	// stage 9: new positions, impulse decision
	cic_pkg::ctx_t      ctx9_c, ctx_s9;
	logic signed [35:0] c1xs, c1ys, c2xs, c2ys, np1x, np1y, np2x, np2y;
	logic [34+NW:0]     sabs_c;
	logic               imp_c;

	always_comb begin
		c1xs   = ctx_s8.sgnx ? -$signed({2'b00, c1x_s8}) : $signed({2'b00, c1x_s8});
		c1ys   = ctx_s8.sgny ? -$signed({2'b00, c1y_s8}) : $signed({2'b00, c1y_s8});
		c2xs   = ctx_s8.sgnx ? -$signed({2'b00, c2x_s8}) : $signed({2'b00, c2x_s8});
		c2ys   = ctx_s8.sgny ? -$signed({2'b00, c2y_s8}) : $signed({2'b00, c2y_s8});
		np1x   = $signed({{4{ctx_s8.crd.p1x[31]}}, ctx_s8.crd.p1x}) - c1xs;
		np1y   = $signed({{4{ctx_s8.crd.p1y[31]}}, ctx_s8.crd.p1y}) - c1ys;
		np2x   = $signed({{4{ctx_s8.crd.p2x[31]}}, ctx_s8.crd.p2x}) + c2xs;
		np2y   = $signed({{4{ctx_s8.crd.p2y[31]}}, ctx_s8.crd.p2y}) + c2ys;
		sabs_c = s_s8[34+NW] ? -s_s8 : s_s8;
		imp_c  = hit_s8 && (s_s8 <= 0);
		ctx9_c = ctx_s8;
		if (hit_s8) begin
			ctx9_c.crd.p1x = cic_pkg::sat32({{6{np1x[35]}}, np1x});
			ctx9_c.crd.p1y = cic_pkg::sat32({{6{np1y[35]}}, np1y});
			ctx9_c.crd.p2x = cic_pkg::sat32({{6{np2x[35]}}, np2x});
			ctx9_c.crd.p2y = cic_pkg::sat32({{6{np2y[35]}}, np2y});
		end
	end

	logic          hit_s9, imp_s9;
	logic [NW-1:0] nxm_s9, nym_s9, sh1_s9, sh2_s9;
	logic [35:0]   amag_s9;

	always_ff @(posedge clk) begin
		if (stage_en[P_E3]) begin
			ctx_s9  <= ctx9_c;
			hit_s9  <= hit_s8;
			imp_s9  <= imp_c;
			nxm_s9  <= nxm_s8;
			nym_s9  <= nym_s8;
			sh1_s9  <= sh1_s8;
			sh2_s9  <= sh2_s8;
			amag_s9 <= sabs_c[34+NW:F];
		end
	end

	// stage 10: restitution scaling
	cic_pkg::ctx_t ctx_s10;
	logic          hit_s10, imp_s10;
	logic [NW-1:0] nxm_s10, nym_s10, sh1_s10, sh2_s10;
	logic [37:0]   k_s10;
	logic [53:0]   kp_c;

	always_comb begin
		kp_c = amag_s9 * (cic_pkg::RESTIT_ONE + {1'b0, restit_q});
	end

	always_ff @(posedge clk) begin
		if (stage_en[P_E4]) begin
			ctx_s10 <= ctx_s9;
			hit_s10 <= hit_s9;
			imp_s10 <= imp_s9;
			nxm_s10 <= nxm_s9;
			nym_s10 <= nym_s9;
			sh1_s10 <= sh1_s9;
			sh2_s10 <= sh2_s9;
			k_s10   <= kp_c[53:cic_pkg::RESTIT_FRAC];
		end
	end

	// stage 11: per-circle speed change
	cic_pkg::ctx_t ctx_s11;
	logic          hit_s11, imp_s11;
	logic [NW-1:0] nxm_s11, nym_s11;
	logic [38:0]   dv1_s11, dv2_s11;
	logic [37+NW:0] d1_c, d2_c;

	always_comb begin
		d1_c = k_s10 * sh1_s10;
		d2_c = k_s10 * sh2_s10;
	end

	always_ff @(posedge clk) begin
		if (stage_en[P_E5]) begin
			ctx_s11 <= ctx_s10;
			hit_s11 <= hit_s10;
			imp_s11 <= imp_s10;
			nxm_s11 <= nxm_s10;
			nym_s11 <= nym_s10;
			dv1_s11 <= d1_c[37+NW:F];
			dv2_s11 <= d2_c[37+NW:F];
		end
	end

	// stage 12: velocity corrections along the normal
	cic_pkg::ctx_t  ctx_s12;
	logic           hit_s12, imp_s12;
	logic [39:0]    cv1x_s12, cv1y_s12, cv2x_s12, cv2y_s12;
	logic [38+NW:0] e1x_c, e1y_c, e2x_c, e2y_c;

	always_comb begin
		e1x_c = nxm_s11 * dv1_s11;
		e1y_c = nym_s11 * dv1_s11;
		e2x_c = nxm_s11 * dv2_s11;
		e2y_c = nym_s11 * dv2_s11;
	end

	always_ff @(posedge clk) begin
		if (stage_en[P_E6]) begin
			ctx_s12  <= ctx_s11;
			hit_s12  <= hit_s11;
			imp_s12  <= imp_s11;
			cv1x_s12 <= e1x_c[38+NW:F];
			cv1y_s12 <= e1y_c[38+NW:F];
			cv2x_s12 <= e2x_c[38+NW:F];
			cv2y_s12 <= e2y_c[38+NW:F];
		end
	end

	// stage 13: new velocities, output register
	cic_pkg::coords_t   out_c, out_s13;
	logic [1:0]         flg_s13;
	logic signed [41:0] s1x, s1y, s2x, s2y;

	always_comb begin
		s1x   = ctx_s12.sgnx ? -$signed({2'b00, cv1x_s12}) : $signed({2'b00, cv1x_s12});
		s1y   = ctx_s12.sgny ? -$signed({2'b00, cv1y_s12}) : $signed({2'b00, cv1y_s12});
		s2x   = ctx_s12.sgnx ? -$signed({2'b00, cv2x_s12}) : $signed({2'b00, cv2x_s12});
		s2y   = ctx_s12.sgny ? -$signed({2'b00, cv2y_s12}) : $signed({2'b00, cv2y_s12});
		out_c = ctx_s12.crd;
		if (imp_s12) begin
			out_c.v1x = cic_pkg::sat32($signed({{10{ctx_s12.crd.v1x[31]}}, ctx_s12.crd.v1x}) - s1x);
			out_c.v1y = cic_pkg::sat32($signed({{10{ctx_s12.crd.v1y[31]}}, ctx_s12.crd.v1y}) - s1y);
			out_c.v2x = cic_pkg::sat32($signed({{10{ctx_s12.crd.v2x[31]}}, ctx_s12.crd.v2x}) + s2x);
			out_c.v2y = cic_pkg::sat32($signed({{10{ctx_s12.crd.v2y[31]}}, ctx_s12.crd.v2y}) + s2y);
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[P_OUT]) begin
			out_s13 <= out_c;
			flg_s13 <= {imp_s12, hit_s12};
		end
	end

	assign m_axis_tdata  = out_s13;
	assign m_axis_tuser  = flg_s13;
	assign m_axis_tvalid = stage_vld_q[P_OUT];

`ifndef ASSERT_OFF
	a_imp_needs_ovl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tuser[1] || m_axis_tuser[0]))
		else $error("impulse flagged without overlap");

	a_full_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input blocked while output is not stalled");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (restit_q == $past(cfg_data)))
		else $error("restitution write lost");
`endif

endmodule
